// ===== hw/rtl/ordered_list_append_search_remove_assert.svh =====
// ----------------------------------------------------------------------------
// Ordered list assertion macros
// Shorthand for the concurrent checks at the end of the list top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_APPEND_SEARCH_REMOVE_ASSERT_SVH
`define ORDERED_LIST_APPEND_SEARCH_REMOVE_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled in reset.
`define OALS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, disabled in reset.
`define OALS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/oals_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Sizes, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package oals_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_EXEC
  } fsm_t;

  // Broadcast to every cell in the execute cycle.
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [VALUE_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/oals_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list cell
// One list slot: compares against the key, passes the first-match flag on,
// loads on insert at the tail and takes its right neighbor on remove.
// ----------------------------------------------------------------------------
module oals_cell (
  input  logic                        clk,
  input  oals_pkg::cell_ctrl_t        ctrl,
  input  logic                        occ,
  input  logic                        tail,
  input  logic                        seen_in,
  input  logic [oals_pkg::VALUE_W-1:0] next_entry,
  output logic                        seen_out,
  output logic [oals_pkg::VALUE_W-1:0] entry
);

  // set from the first matching slot onward
  assign seen_out = seen_in | (occ & (entry == ctrl.key));

  always_ff @(posedge clk) begin
    if (ctrl.ins && tail) begin
      entry <= ctrl.key;
    end else if (ctrl.rem && seen_out && occ) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== hw/rtl/ordered_list_append_search_remove.sv =====
// ----------------------------------------------------------------------------
// Ordered list with append, search and remove
// Insertion-ordered list of signed 32-bit values held in a row of cells.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready command value  | into block
//  out     | out_valid out_ready found status | out of block
//          | count                            |
//
//  An item passes an accept cycle, which latches command and value, and an
//  execute cycle, in which every cell compares in parallel, ripples the
//  first-match flag along the row and shifts or loads in the same edge.
//  The execute cycle waits while a previous result is still not taken; the
//  next item is accepted while a result waits in the output register.
//  Reset (rst, synchronous) clears the count, the sequencer and out_valid;
//  slot contents are not cleared, slots at or above the count are never used.
//
`include "ordered_list_append_search_remove_assert.svh"

module ordered_list_append_search_remove (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [oals_pkg::CMD_W-1:0]    command,
  input  logic signed [oals_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [oals_pkg::STATUS_W-1:0] status,
  output logic [oals_pkg::COUNT_W-1:0]  count
);

  oals_pkg::fsm_t                state, state_next;
  oals_pkg::cmd_t                cmd;
  logic [oals_pkg::VALUE_W-1:0]  key;
  logic [oals_pkg::CNT_W-1:0]    cnt, cnt_next;
  logic                          fire;

  oals_pkg::cell_ctrl_t          ctrl;
  logic [oals_pkg::CAPACITY:0]   seen;
  logic [oals_pkg::VALUE_W-1:0]  entry [oals_pkg::CAPACITY];
  logic                          occ  [oals_pkg::CAPACITY];
  logic                          tail [oals_pkg::CAPACITY];

  logic                          found_w;
  oals_pkg::status_t             status_w;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oals_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    fire       = 1'b0;
    case (state)
      oals_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = oals_pkg::FSM_EXEC;
        end
      end
      oals_pkg::FSM_EXEC: begin
        // the output register must be free before the list changes
        if (!out_valid || out_ready) begin
          fire       = 1'b1;
          state_next = oals_pkg::FSM_IDLE;
        end
      end
      default: state_next = oals_pkg::FSM_IDLE;
    endcase
  end

  // command and operand, held for the execute cycle
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= oals_pkg::cmd_t'(command);
      key <= value;
    end
  end

  // ---- cell row ----
  always_comb begin
    ctrl.key = key;
    ctrl.ins = fire && (cmd == oals_pkg::CMD_INSERT);
    ctrl.rem = fire && (cmd == oals_pkg::CMD_REMOVE);
  end

  assign seen[0] = 1'b0;

  for (genvar i = 0; i < oals_pkg::CAPACITY; i++) begin : g_cell
    logic [oals_pkg::VALUE_W-1:0] nxt;

    assign occ[i]  = oals_pkg::CNT_W'(i) < cnt;
    assign tail[i] = oals_pkg::CNT_W'(i) == cnt;

    // last slot has no right neighbor; what it takes lands above the count
    if (i == oals_pkg::CAPACITY - 1) begin : g_last
      assign nxt = entry[i];
    end else begin : g_mid
      assign nxt = entry[i+1];
    end

    oals_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .tail       (tail[i]),
      .seen_in    (seen[i]),
      .next_entry (nxt),
      .seen_out   (seen[i+1]),
      .entry      (entry[i])
    );
  end

  // ---- result and count ----
  always_comb begin
    found_w  = 1'b0;
    status_w = oals_pkg::ST_OK;
    cnt_next = cnt;
    case (cmd)
      oals_pkg::CMD_INSERT: begin
        if (cnt == oals_pkg::CNT_W'(oals_pkg::CAPACITY)) begin
          status_w = oals_pkg::ST_FULL;
        end else begin
          cnt_next = cnt + oals_pkg::CNT_W'(1);
        end
      end
      oals_pkg::CMD_SEARCH, oals_pkg::CMD_REMOVE: begin
        if (cnt == '0) begin
          status_w = oals_pkg::ST_EMPTY;
        end else if (!seen[oals_pkg::CAPACITY]) begin
          status_w = oals_pkg::ST_NOT_FOUND;
        end else begin
          found_w = 1'b1;
          if (cmd == oals_pkg::CMD_REMOVE) begin
            cnt_next = cnt - oals_pkg::CNT_W'(1);
          end
        end
      end
      default: ;  // unused code: no change, ok
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      found  <= found_w;
      status <= status_w;
      count  <= oals_pkg::COUNT_W'(cnt_next);
    end
  end

  // ---- checks ----
  `OALS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= oals_pkg::CNT_W'(oals_pkg::CAPACITY), "count above capacity")
  `OALS_ASSERT_NOW(a_full_cnt, fire && (status_w == oals_pkg::ST_FULL), cnt == oals_pkg::CNT_W'(oals_pkg::CAPACITY), "full reported below capacity")
  `OALS_ASSERT_NEXT(a_rem_dec, fire && ctrl.rem && found_w, cnt == $past(cnt) - oals_pkg::CNT_W'(1), "remove did not shrink list")

endmodule

// ===== tb/sv/tb_ordered_list_append_search_remove.sv =====
// ----------------------------------------------------------------------------
// Ordered list testbench
// Drives insert, search and remove items with random gaps on both channels.
// An in-bench copy of the list predicts each result, and the results are
// checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_ordered_list_append_search_remove;
  import oals_pkg::*;

  localparam int PERIOD       = 8;
  localparam int RESET_CYCLES = 8;
  localparam int PHASE_ITEMS  = 475;      // random items per idling phase
  localparam int BURST_LEN    = 24;       // items sharing one command mix
  localparam int POOL_SIZE    = 10;       // small value pool so removes hit
  localparam int TAIL_CYCLES  = 20;       // quiet time after the last result
  localparam int CYCLE_LIMIT  = 200000;

  // Command mixes for the random bursts.
  localparam int MIX_FILL    = 0;
  localparam int MIX_DRAIN   = 1;
  localparam int MIX_BALANCE = 2;

  // One input item as queued for the driver.
  typedef struct {
    cmd_t               op;
    logic [VALUE_W-1:0] val;
    int                 phase;
    bit                 drain_first;  // hold off until all results are back
  } list_cmd_t;

  // One result of the list.
  typedef struct {
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } list_resp_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           command = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       found;
  logic [STATUS_W-1:0]        status;
  logic [COUNT_W-1:0]         count;

  // Idling per phase: sender light / receiver heavy, then swapped, then none.
  int send_gap_pct [3] = '{7, 55, 0};
  int recv_stall_pct [3] = '{55, 7, 0};

  list_cmd_t  cmd_queue [$];        // items not yet put on the input
  list_resp_t results_due [$];      // predicted results not yet seen
  list_cmd_t  live_item;            // item currently on the input port
  bit         in_taken = 1'b0;      // input item accepted at the last edge
  int         recv_phase = 0;

  // Shadow of the list contents, slot 0 oldest.
  logic [VALUE_W-1:0] list_vals [CAPACITY];
  int                 list_len = 0;

  int errors = 0;
  int cycles = 0;
  int n_insert = 0, n_search = 0, n_remove = 0;
  int n_full = 0, n_empty = 0, n_miss = 0, n_hit = 0, n_to_empty = 0;

  ordered_list_append_search_remove uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .status    (status),
    .count     (count)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Apply one command to the shadow list and return the result it produces.
  function automatic list_resp_t list_apply(cmd_t op, logic [VALUE_W-1:0] key);
    list_resp_t r;
    int         hit;
    r.found  = 1'b0;
    r.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_vals[list_len] = key;
          list_len++;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // earliest match only
          hit = -1;
          for (int i = 0; i < list_len; i++) begin
            if (hit < 0 && list_vals[i] == key) hit = i;
          end
          if (hit < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.found = 1'b1;
            if (op == CMD_REMOVE) begin
              // close the gap, order of the rest is kept
              for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
              list_len--;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic queue_cmd(cmd_t op, logic [VALUE_W-1:0] val, int phase, bit drain);
    list_cmd_t c;
    c.op          = op;
    c.val         = val;
    c.phase       = phase;
    c.drain_first = drain;
    cmd_queue.push_back(c);
  endtask

  // Random word, leaning now and then on the extremes of the signed range, zero and all ones.
  function automatic logic [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: puts queued items on the input at the falling edge. A held item
  // stays on the port untouched until the monitor saw it accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    bit launch;
    launch = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (cmd_queue.size() != 0) begin
        if (cmd_queue[0].drain_first && results_due.size() != 0) begin
          launch = 1'b0;    // wait until the block has returned everything
        end else if ($urandom_range(0, 99) < send_gap_pct[cmd_queue[0].phase]) begin
          launch = 1'b0;
        end else begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        live_item = cmd_queue.pop_front();
        command  <= live_item.op;
        value    <= live_item.val;
      end
      in_valid <= launch;
    end
  end

  // Receiver stalls, rate follows the phase of the last accepted item.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct[recv_phase]);
  end

  // --------------------------------------------------------------------------
  // Monitor: at each rising edge first check a delivered result against the
  // oldest prediction, then predict for an item accepted at the same edge.
  // A result never comes out in its own accept cycle, so the order is safe.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    list_resp_t want;
    list_resp_t got;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.found  = found;
        got.status = status_t'(status);
        got.count  = count;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result found=%0b status=%0d count=%0d",
                   $time, found, status, count);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0b actual %0b",
                     $time, want.found, got.found);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, want.status, status);
            errors++;
          end
          if (got.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d actual %0d",
                     $time, want.count, got.count);
            errors++;
          end
        end
      end

      in_taken = in_valid && in_ready;
      if (in_taken) begin
        recv_phase = live_item.phase;
        want = list_apply(cmd_t'(command), value);
        results_due.push_back(want);
        case (cmd_t'(command))
          CMD_INSERT: n_insert++;
          CMD_SEARCH: n_search++;
          default:    n_remove++;
        endcase
        case (want.status)
          ST_FULL:      n_full++;
          ST_EMPTY:     n_empty++;
          ST_NOT_FOUND: n_miss++;
          default:      ;
        endcase
        if (want.found) n_hit++;
        if (cmd_t'(command) == CMD_REMOVE && want.found && want.count == 0) n_to_empty++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    logic [VALUE_W-1:0] fill [CAPACITY];
    logic [VALUE_W-1:0] pool [POOL_SIZE];
    logic [VALUE_W-1:0] v;
    int                 mix;
    int                 roll;
    cmd_t               op;

    // Directed: empty list cases, lone entry removed, fill to full,
    // full insert, hits and misses, removal of the earliest of two copies.
    queue_cmd(CMD_SEARCH, 32'h0000_0000, 0, 1'b1);
    queue_cmd(CMD_REMOVE, 32'hFFFF_FFFF, 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h7FFF_FFFF, 0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'h7FFF_FFFF, 0, 1'b0);   // list back to empty
    queue_cmd(CMD_REMOVE, 32'h7FFF_FFFF, 0, 1'b0);
    for (int i = 0; i < CAPACITY; i++) fill[i] = $urandom;
    fill[0] = 32'h8000_0000;
    fill[1] = 32'h7FFF_FFFF;
    fill[2] = 32'h0000_0000;
    fill[3] = 32'hFFFF_FFFF;
    fill[4] = 32'h5555_5555;
    fill[5] = 32'hAAAA_AAAA;
    fill[CAPACITY - 3] = fill[3];                    // duplicate of an earlier entry
    for (int i = 0; i < CAPACITY; i++) queue_cmd(CMD_INSERT, fill[i], 0, 1'b0);
    queue_cmd(CMD_INSERT, 32'h0000_0001, 0, 1'b0);   // full
    queue_cmd(CMD_SEARCH, fill[CAPACITY - 1], 0, 1'b0);
    queue_cmd(CMD_SEARCH, 32'h1234_5678, 0, 1'b0);
    queue_cmd(CMD_REMOVE, fill[3], 0, 1'b0);         // takes the earlier copy
    queue_cmd(CMD_SEARCH, fill[3], 0, 1'b0);         // later copy still there
    queue_cmd(CMD_REMOVE, 32'h1234_5678, 0, 1'b0);
    queue_cmd(CMD_REMOVE, fill[0], 0, 1'b0);

    // Random: bursts that fill, drain or mix, with values mostly from a
    // small pool so that matches, full and empty all come up often.
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = rand_word();
    for (int ph = 0; ph < 3; ph++) begin
      mix = MIX_BALANCE;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % BURST_LEN == 0) begin
          mix = $urandom_range(MIX_FILL, MIX_BALANCE);
          pool[$urandom_range(0, POOL_SIZE - 1)] = rand_word();
          pool[$urandom_range(0, POOL_SIZE - 1)] = rand_word();
        end
        roll = $urandom_range(0, 99);
        case (mix)
          MIX_FILL:  op = (roll < 75) ? CMD_INSERT : (roll < 85) ? CMD_SEARCH : CMD_REMOVE;
          MIX_DRAIN: op = (roll < 20) ? CMD_INSERT : (roll < 35) ? CMD_SEARCH : CMD_REMOVE;
          default:   op = (roll < 40) ? CMD_INSERT : (roll < 65) ? CMD_SEARCH : CMD_REMOVE;
        endcase
        // a few stray values that almost never match
        v = ($urandom_range(0, 99) < 8) ? $urandom : pool[$urandom_range(0, POOL_SIZE - 1)];
        queue_cmd(op, v, ph, (n == 0) || ($urandom_range(0, 99) == 0));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d inserts, %0d searches, %0d removes; %0d matched",
             n_insert, n_search, n_remove, n_hit);
    $display("hit full %0d, empty %0d, no match %0d times; emptied by remove %0d times",
             n_full, n_empty, n_miss, n_to_empty);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/oals_pkg.sv
hw/rtl/oals_cell.sv
hw/rtl/ordered_list_append_search_remove.sv
tb/sv/tb_ordered_list_append_search_remove.sv
